// ----- sv/cos_pkg.sv -----
// ----------------------------------------------------------------------------
// cos_pkg: circle overlap separation package
// Shared widths, step counts and controller/datapath command types.
// ----------------------------------------------------------------------------
package cos_pkg;

  localparam int POS_BITS_DEF = 24;   // default position width
  localparam int ID_W         = 16;
  localparam int RAD_W        = 16;
  localparam int MW           = 17;   // radius sum
  localparam int DW           = 18;   // delta once the far test has passed
  localparam int D2W          = 35;   // squared distance
  localparam int NW           = 35;   // magnitude of delta * overlap
  localparam int SQ_STEPS     = 18;   // one root bit per step
  localparam int DIV_STEPS    = 35;   // one quotient bit per step
  localparam int CW           = 6;    // step counter

  typedef struct packed {
    logic take;
    logic load;
    logic delta;
    logic sqx;
    logic sqy;
    logic msq;
    logic sq_init;
    logic sq_step;
    logic mulx;
    logic muly;
    logic div_init;
    logic div_step;
    logic upd;
  } cos_cmd_t;

  typedef struct packed {
    logic is_load;
    logic same_id;
    logic far;
    logic no_hit;
  } cos_sts_t;

endpackage

// ----- sv/cos_req_if.sv -----
// ----------------------------------------------------------------------------
// cos_req_if: request channel
// Valid/ready channel carrying one unit item.
// ----------------------------------------------------------------------------
interface cos_req_if #(
  parameter int PW = 24
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [15:0]          unit_id;
  logic signed [PW-1:0] pos_x;
  logic signed [PW-1:0] pos_y;
  logic [15:0]          radius;

  modport source (output valid, req_type, unit_id, pos_x, pos_y, radius, input ready);
  modport sink   (input valid, req_type, unit_id, pos_x, pos_y, radius, output ready);
endinterface

// ----- sv/cos_rsp_if.sv -----
// ----------------------------------------------------------------------------
// cos_rsp_if: response channel
// Valid/ready channel carrying the self position and overlap flag after one item.
// ----------------------------------------------------------------------------
interface cos_rsp_if #(
  parameter int PW = 24
);
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] self_x;
  logic signed [PW-1:0] self_y;
  logic                 overlapped;

  modport source (output valid, self_x, self_y, overlapped, input ready);
  modport sink   (input valid, self_x, self_y, overlapped, output ready);
endinterface

// ----- sv/cos_ctrl.sv -----
// ----------------------------------------------------------------------------
// cos_ctrl: sequencing controller
// Walks one item through load, or test, square root, divide and update.
// ----------------------------------------------------------------------------
module cos_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cos_pkg::cos_sts_t sts_i,
  output cos_pkg::cos_cmd_t cmd_o
);
  import cos_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_TEST = 4'd2;
  localparam logic [3:0] S_SQY  = 4'd3;
  localparam logic [3:0] S_MSQ  = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_MULX = 4'd7;
  localparam logic [3:0] S_MULY = 4'd8;
  localparam logic [3:0] S_DIVI = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_UPD  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.is_load) begin
          cmd_o.load = 1'b1;
          state_d    = S_OUT;
        end else begin
          cmd_o.delta = 1'b1;
          state_d     = S_TEST;
        end
      end
      S_TEST: begin
        if (sts_i.same_id || sts_i.far) begin
          state_d = S_OUT;
        end else begin
          cmd_o.sqx = 1'b1;
          state_d   = S_SQY;
        end
      end
      S_SQY: begin
        cmd_o.sqy = 1'b1;
        state_d   = S_MSQ;
      end
      S_MSQ: begin
        cmd_o.msq = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (sts_i.no_hit) begin
          state_d = S_OUT;
        end else begin
          cmd_o.sq_init = 1'b1;
          cnt_d         = CW'(SQ_STEPS - 1);
          state_d       = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.sq_step = 1'b1;
        cnt_d         = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_MULX;
      end
      S_MULX: begin
        cmd_o.mulx = 1'b1;
        state_d    = S_MULY;
      end
      S_MULY: begin
        cmd_o.muly = 1'b1;
        state_d    = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = CW'(DIV_STEPS - 1);
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- sv/cos_dp.sv -----
// ----------------------------------------------------------------------------
// cos_dp: separation datapath
// Self state, squares, bit-serial square root, twin dividers, saturating update.
// ----------------------------------------------------------------------------
module cos_dp #(
  parameter int PW = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cos_pkg::cos_cmd_t    cmd_i,
  output cos_pkg::cos_sts_t    sts_o,
  input  logic                 req_type_i,
  input  logic [15:0]          unit_id_i,
  input  logic signed [PW-1:0] pos_x_i,
  input  logic signed [PW-1:0] pos_y_i,
  input  logic [15:0]          radius_i,
  output logic signed [PW-1:0] self_x_o,
  output logic signed [PW-1:0] self_y_o,
  output logic                 overlapped_o
);
  import cos_pkg::*;

  localparam int EW = (PW + 1 > DW) ? PW + 1 : DW;
  localparam int SW = ((PW > DW + 1) ? PW : DW + 1) + 1;

  // item latch
  logic                 type_q;
  logic [ID_W-1:0]      id_q;
  logic signed [PW-1:0] ox_q, oy_q;
  logic [RAD_W-1:0]     rad_q;
  // self state
  logic signed [PW-1:0] sx_q, sy_q;
  logic [ID_W-1:0]      sid_q;
  logic [RAD_W-1:0]     srad_q;
  logic                 hit_q;
  // work registers
  logic signed [EW-1:0] dx_q, dy_q;
  logic [MW-1:0]        m_q;
  logic [D2W-1:0]       p_q, d2_q, m2_q;
  logic [D2W-1:0]       n_q, bit_q;
  logic [D2W:0]         root_q;
  logic signed [2*DW-1:0] numx_q, numy_q;
  logic                 negx_q, negy_q;
  logic [NW-1:0]        qx_q, qy_q;
  logic [DW-1:0]        rx_q, ry_q;

  logic [EW-1:0]        absx, absy;
  logic signed [DW-1:0] dx_s, dy_s;
  logic [MW-1:0]        rdist, ov;
  logic [D2W:0]         trial;
  logic [DW-1:0]        dv;
  logic [DW:0]          shx, shy;
  logic [2*DW-1:0]      magx, magy;
  logic signed [DW:0]   px, py;
  logic signed [SW-1:0] sumx, sumy;

  function automatic logic signed [PW-1:0] sat(input logic signed [SW-1:0] s);
    logic [SW-PW:0] top;
    top = s[SW-1:PW-1];
    if (&top || ~|top) return s[PW-1:0];
    return {s[SW-1], {(PW-1){~s[SW-1]}}};
  endfunction

  assign absx  = dx_q[EW-1] ? EW'(-dx_q) : EW'(dx_q);
  assign absy  = dy_q[EW-1] ? EW'(-dy_q) : EW'(dy_q);
  assign dx_s  = dx_q[DW-1:0];
  assign dy_s  = dy_q[DW-1:0];
  assign rdist = root_q[MW-1:0];
  assign ov    = m_q - rdist;
  assign trial = root_q + {1'b0, bit_q};
  assign dv    = {rdist, 1'b0};
  assign shx   = {rx_q, qx_q[NW-1]};
  assign shy   = {ry_q, qy_q[NW-1]};
  assign magx  = numx_q[2*DW-1] ? (2*DW)'(-numx_q) : (2*DW)'(numx_q);
  assign magy  = numy_q[2*DW-1] ? (2*DW)'(-numy_q) : (2*DW)'(numy_q);

  always_comb begin
    if (rdist == '0) begin
      px = (DW+1)'({1'b0, ov[MW-1:1]});
      py = '0;
    end else begin
      px = negx_q ? -$signed({1'b0, qx_q[DW-1:0]}) : $signed({1'b0, qx_q[DW-1:0]});
      py = negy_q ? -$signed({1'b0, qy_q[DW-1:0]}) : $signed({1'b0, qy_q[DW-1:0]});
    end
  end

  assign sumx = SW'(sx_q) + SW'(px);
  assign sumy = SW'(sy_q) + SW'(py);

  assign sts_o.is_load = ~type_q;
  assign sts_o.same_id = (id_q == sid_q);
  assign sts_o.far     = (absx >= EW'(m_q)) || (absy >= EW'(m_q));
  assign sts_o.no_hit  = (d2_q >= m2_q);

  // item latch and work registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      type_q <= req_type_i;
      id_q   <= unit_id_i;
      ox_q   <= pos_x_i;
      oy_q   <= pos_y_i;
      rad_q  <= radius_i;
    end
    if (cmd_i.delta) begin
      dx_q <= EW'(sx_q) - EW'(ox_q);
      dy_q <= EW'(sy_q) - EW'(oy_q);
      m_q  <= MW'(srad_q) + MW'(rad_q);
    end
    if (cmd_i.sqx) p_q  <= D2W'(dx_s * dx_s);
    if (cmd_i.sqy) d2_q <= p_q + D2W'(dy_s * dy_s);
    if (cmd_i.msq) m2_q <= D2W'(m_q * m_q);
    if (cmd_i.sq_init) begin
      n_q    <= d2_q;
      root_q <= '0;
      bit_q  <= D2W'(1) << (2 * (SQ_STEPS - 1));
    end else if (cmd_i.sq_step) begin
      if ({1'b0, n_q} >= trial) begin
        n_q    <= D2W'({1'b0, n_q} - trial);
        root_q <= (root_q >> 1) + {1'b0, bit_q};
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.mulx) numx_q <= dx_s * $signed({1'b0, ov});
    if (cmd_i.muly) numy_q <= dy_s * $signed({1'b0, ov});
    if (cmd_i.div_init) begin
      negx_q <= numx_q[2*DW-1];
      negy_q <= numy_q[2*DW-1];
      qx_q   <= magx[NW-1:0];
      qy_q   <= magy[NW-1:0];
      rx_q   <= '0;
      ry_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (shx >= {1'b0, dv}) begin
        rx_q <= DW'(shx - {1'b0, dv});
        qx_q <= {qx_q[NW-2:0], 1'b1};
      end else begin
        rx_q <= shx[DW-1:0];
        qx_q <= {qx_q[NW-2:0], 1'b0};
      end
      if (shy >= {1'b0, dv}) begin
        ry_q <= DW'(shy - {1'b0, dv});
        qy_q <= {qy_q[NW-2:0], 1'b1};
      end else begin
        ry_q <= shy[DW-1:0];
        qy_q <= {qy_q[NW-2:0], 1'b0};
      end
    end
  end

  // self state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q   <= '0;
      sy_q   <= '0;
      sid_q  <= '0;
      srad_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (cmd_i.take) hit_q <= 1'b0;
      if (cmd_i.load) begin
        sx_q   <= ox_q;
        sy_q   <= oy_q;
        sid_q  <= id_q;
        srad_q <= rad_q;
      end
      if (cmd_i.upd) begin
        sx_q  <= sat(sumx);
        sy_q  <= sat(sumy);
        hit_q <= 1'b1;
      end
    end
  end

  assign self_x_o     = sx_q;
  assign self_y_o     = sy_q;
  assign overlapped_o = hit_q;

endmodule

// ----- sv/circle_overlap_separation_top.sv -----
// ----------------------------------------------------------------------------
// circle_overlap_separation_top: circle overlap separation
// Pushes one moving unit away from the other units it overlaps, by half the overlap.
// ----------------------------------------------------------------------------
// Paths: a load item goes from decode straight to the result; a skipped or
//   far-apart item ends after the far test; a tested but clear item ends
//   after the squares; a pushed item also runs 18 root and 35 divide steps.
// Throughput: one item at a time; the next transfer is taken the cycle after
//   the result transfer at the earliest.
// Reset: asynchronous, active low; self position, id and radius clear to zero.
// ----------------------------------------------------------------------------
module circle_overlap_separation_top #(
  parameter int POSITION_BITS = cos_pkg::POS_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cos_req_if.sink   req_i,
  cos_rsp_if.source rsp_o
);
  import cos_pkg::*;

  cos_cmd_t cmd;   // controller commands to the datapath
  cos_sts_t sts;   // datapath test results back

  // Sequence each item: decode, far test, squares, root, products, divide,
  // update, then hold the result until the response transfer completes.
  cos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Self state doubles as the result register: it stays stable while the
  // response waits.
  cos_dp #(
    .PW (POSITION_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_i.req_type),
    .unit_id_i    (req_i.unit_id),
    .pos_x_i      (req_i.pos_x),
    .pos_y_i      (req_i.pos_y),
    .radius_i     (req_i.radius),
    .self_x_o     (rsp_o.self_x),
    .self_y_o     (rsp_o.self_y),
    .overlapped_o (rsp_o.overlapped)
  );

endmodule

// ----- tb/sv/cos_tb_checker.sv -----
// ----------------------------------------------------------------------------
// cos_tb_checker: overlap separation scoreboard
// Watches the request and response channels, predicts the self position
// after every accepted request and compares each response field by field.
// ----------------------------------------------------------------------------
module cos_tb_checker #(
  parameter int PW = 24
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  cos_req_if     req_i,
  cos_rsp_if     rsp_i,
  output int     fail_count_o,
  output int     pending_o,
  output int     push_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [PW-1:0] sx;
    logic signed [PW-1:0] sy;
    logic                 hit;
  } self_pos_t;

  logic signed [PW-1:0] self_x_q, self_y_q;
  logic [15:0]          self_id_q;
  logic [15:0]          self_rad_q;
  self_pos_t            expected_pos_q[$];
  int                   fails;
  int                   pushes;

  assign fail_count_o = fails;
  assign pending_o    = expected_pos_q.size();
  assign push_count_o = pushes;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint clamp_pos(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (PW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Apply one request to the self state and return the resulting position.
  task automatic separate(input logic rt, input logic [15:0] id,
                          input logic signed [PW-1:0] ox, input logic signed [PW-1:0] oy,
                          input logic [15:0] rad, output self_pos_t res);
    longint dx, dy, m, root_d, ov, px, py;
    longint unsigned d2, m2;
    res.hit = 1'b0;
    if (rt == 1'b0) begin
      self_id_q  = id;
      self_x_q   = ox;
      self_y_q   = oy;
      self_rad_q = rad;
    end else if (id != self_id_q) begin
      dx = longint'(self_x_q) - longint'(ox);
      dy = longint'(self_y_q) - longint'(oy);
      m  = longint'(self_rad_q) + longint'(rad);
      if ((dx < 0 ? -dx : dx) < m && (dy < 0 ? -dy : dy) < m) begin
        d2 = dx * dx + dy * dy;
        m2 = m * m;
        if (d2 < m2) begin
          root_d = isqrt(d2);
          ov     = m - root_d;
          if (root_d == 0) begin
            px = ov / 2;
            py = 0;
          end else begin
            px = (dx * ov) / (2 * root_d);
            py = (dy * ov) / (2 * root_d);
          end
          self_x_q = PW'(clamp_pos(longint'(self_x_q) + px));
          self_y_q = PW'(clamp_pos(longint'(self_y_q) + py));
          res.hit  = 1'b1;
        end
      end
    end
    res.sx = self_x_q;
    res.sy = self_y_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    self_pos_t exp_r, act_r;
    if (!rst_ni) begin
      self_x_q   = '0;
      self_y_q   = '0;
      self_id_q  = '0;
      self_rad_q = '0;
      fails      = 0;
      pushes     = 0;
      expected_pos_q.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        separate(req_i.req_type, req_i.unit_id, req_i.pos_x, req_i.pos_y,
                 req_i.radius, exp_r);
        if (exp_r.hit) pushes++;
        expected_pos_q.push_back(exp_r);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        act_r.sx  = rsp_i.self_x;
        act_r.sy  = rsp_i.self_y;
        act_r.hit = rsp_i.overlapped;
        if (expected_pos_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%t: response transfer with nothing outstanding", $realtime);
        end else begin
          exp_r = expected_pos_q.pop_front();
          if (exp_r.sx !== act_r.sx || exp_r.sy !== act_r.sy || exp_r.hit !== act_r.hit) begin
            fails++;
            if (fails <= 10)
              $display("%t: mismatch exp x=%0d y=%0d hit=%0b got x=%0d y=%0d hit=%0b",
                       $realtime, exp_r.sx, exp_r.sy, exp_r.hit,
                       act_r.sx, act_r.sy, act_r.hit);
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/tb_circle_overlap_separation_top.sv -----
// ----------------------------------------------------------------------------
// tb_circle_overlap_separation_top: overlap separation testbench
// Drives directed and random unit transfers, random stalls on both channels,
// and reports the verdict from the scoreboard's failure count.
// ----------------------------------------------------------------------------
module tb_circle_overlap_separation_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW       = cos_pkg::POS_BITS_DEF;
  localparam int N_RANDOM = 1500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, push_count;
  int   idle_pct = 36;   // idle odds per hundred; zeroed for a calm stretch
  int   sent_count = 0;

  cos_req_if #(.PW(PW)) req_if ();
  cos_rsp_if #(.PW(PW)) rsp_if ();

  circle_overlap_separation_top #(.POSITION_BITS(PW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  cos_tb_checker #(.PW(PW)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .push_count_o (push_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: change ready on the falling edge only.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Send one transfer: optional idle gap, then hold valid until accepted.
  task automatic send_unit(input logic rt, input logic [15:0] id,
                           input logic signed [PW-1:0] x, input logic signed [PW-1:0] y,
                           input logic [15:0] rad);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= rt;
    req_if.unit_id  <= id;
    req_if.pos_x    <= x;
    req_if.pos_y    <= y;
    req_if.radius   <= rad;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    sent_count++;
  endtask

  // Random offset that mostly lands inside the overlap reach of sum m.
  function automatic logic signed [PW-1:0] near(input logic signed [PW-1:0] c, input int m);
    longint v;
    v = longint'(c) + $signed($urandom_range(2 * m + 2)) - (m + 1);
    if (v > (64'sd1 <<< (PW - 1)) - 1) v = (64'sd1 <<< (PW - 1)) - 1;
    if (v < -(64'sd1 <<< (PW - 1))) v = -(64'sd1 <<< (PW - 1));
    return PW'(v);
  endfunction

  localparam logic signed [PW-1:0] P_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] P_MIN = {1'b1, {(PW-1){1'b0}}};

  initial begin
    logic signed [PW-1:0] cx, cy, ox, oy;
    logic [15:0]          sid, srad, orad;
    int                   n;
    req_if.valid    = 1'b0;
    req_if.req_type = 1'b0;
    req_if.unit_id  = '0;
    req_if.pos_x    = '0;
    req_if.pos_y    = '0;
    req_if.radius   = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: test before any load, coincident centres, same id, touching,
    // far apart, saturation at both extremes, full radii.
    send_unit(1'b1, 16'd1, 24'sd0, 24'sd0, 16'd100);       // reset state, coincident
    send_unit(1'b1, 16'd0, 24'sd5, 24'sd5, 16'd100);       // same id as reset
    send_unit(1'b0, 16'd7, 24'sd1000, 24'sd1000, 16'd200);
    send_unit(1'b1, 16'd7, 24'sd1000, 24'sd1000, 16'd200); // same id skipped
    send_unit(1'b1, 16'd8, 24'sd1000, 24'sd1000, 16'd200); // coincident
    send_unit(1'b0, 16'd7, 24'sd0, 24'sd0, 16'd300);
    send_unit(1'b1, 16'd9, 24'sd500, 24'sd0, 16'd200);     // touching exactly
    send_unit(1'b1, 16'd9, 24'sd300, 24'sd400, 16'd200);   // touching on diagonal
    send_unit(1'b1, 16'd9, 24'sd100000, 24'sd0, 16'd200);  // far apart
    send_unit(1'b1, 16'd9, 24'sd100, -24'sd50, 16'd200);
    send_unit(1'b0, 16'hFFFF, P_MAX, P_MAX, 16'hFFFF);
    send_unit(1'b1, 16'h0000, P_MAX - 24'sd10, P_MAX - 24'sd20, 16'hFFFF); // saturate
    send_unit(1'b1, 16'h1234, P_MAX, P_MAX, 16'hFFFF);
    send_unit(1'b0, 16'h8000, P_MIN, P_MIN, 16'hFFFF);
    send_unit(1'b1, 16'h0001, P_MIN + 24'sd3, P_MIN + 24'sd7, 16'hFFFF);
    send_unit(1'b1, 16'h0002, P_MIN, P_MIN, 16'd0);
    send_unit(1'b0, 16'h5555, -24'sd1, 24'sd1, 16'd0);
    send_unit(1'b1, 16'hAAAA, -24'sd1, 24'sd1, 16'd0);     // zero radii, no push
    send_unit(1'b1, 16'hAAAA, 24'sd0, 24'sd1, 16'd2);

    // Pressure: hold off until everything outstanding has drained.
    wait (pending == 0);
    @(negedge clk_i);

    // Random: mostly a load followed by a burst of nearby units.
    n = 0;
    while (n < N_RANDOM) begin
      idle_pct = (n >= 600 && n < 800) ? 0 : 36;
      if ($urandom_range(9) == 0) begin
        send_unit(1'($urandom_range(1)), 16'($urandom), PW'($urandom), PW'($urandom),
                  16'($urandom));
        n++;
      end else begin
        sid  = 16'($urandom);
        srad = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4095));
        cx   = ($urandom_range(7) == 0) ? PW'($urandom) : PW'($signed($urandom_range(8191)) - 4096);
        cy   = ($urandom_range(7) == 0) ? PW'($urandom) : PW'($signed($urandom_range(8191)) - 4096);
        send_unit(1'b0, sid, cx, cy, srad);
        n++;
        repeat ($urandom_range(8, 1)) begin
          orad = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4095));
          ox   = near(cx, int'(srad) + int'(orad));
          oy   = near(cy, int'(srad) + int'(orad));
          if ($urandom_range(15) == 0) begin ox = cx; oy = cy; end
          send_unit(1'b1, ($urandom_range(15) == 0) ? sid : 16'($urandom), ox, oy, orad);
          n++;
        end
      end
    end
    req_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (70) @(posedge clk_i);

    $display("run covered %0d request transfers, %0d of which pushed the self unit",
             sent_count, push_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
